// File: rtl/fcpu_pkg.sv
package fcpu_pkg;

  localparam int POS_W = 32;
  localparam int VEC_W = 16;
  localparam int ANG_W = 16;
  localparam int OP_W  = 4;
  localparam int LIM_W = 15;

  typedef enum logic [OP_W-1:0] {
    OP_SETPOS   = 4'd0,
    OP_MOVE     = 4'd1,
    OP_STRAFE   = 4'd2,
    OP_FLY      = 4'd3,
    OP_ADDYAW   = 4'd4,
    OP_ADDPITCH = 4'd5,
    OP_ADDROLL  = 4'd6,
    OP_SETYAW   = 4'd7,
    OP_SETPITCH = 4'd8,
    OP_SETROLL  = 4'd9
  } op_t;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int NSTEPS       = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int IT_W         = $clog2(NSTEPS);

  // cordic datapath widths
  localparam int CW = FRAC_BITS + 4;
  localparam int ZW = 34;

  localparam longint GAIN_Q30  = 64'h26DD3B6A;
  localparam int     GAIN_SH   = 30 - FRAC_BITS;
  localparam longint CORDIC_X0 = (GAIN_Q30 + (64'sd1 <<< (GAIN_SH - 1))) >>> GAIN_SH;

  // rounding from cordic fraction to q1.14
  localparam int Q14_SH  = FRAC_BITS - 14;
  localparam int Q14_RSH = (Q14_SH > 0) ? Q14_SH : 0;
  localparam int Q14_LSH = (Q14_SH < 0) ? -Q14_SH : 0;
  localparam int Q14_RND = (Q14_SH > 0) ? (1 << (Q14_RSH - 1)) : 0;
  localparam int QW      = CW + Q14_LSH + 1;

  localparam int PROD_W  = POS_W + VEC_W;
  localparam int Q14_ONE = 16384;
  localparam int PROD_RND = 8192;

  localparam logic [LIM_W-1:0] PITCH_LIMIT_RST = LIM_W'(16202);
  localparam logic signed [POS_W-1:0] POS_Z_RST = -32'sd131072;

  function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [VEC_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [QW-1:0] t;
    t = (QW'(v) + QW'(Q14_RND)) >>> Q14_RSH;
    t = t <<< Q14_LSH;
    if (t > QW'(Q14_ONE)) begin
      t = QW'(Q14_ONE);
    end else if (t < -QW'(Q14_ONE)) begin
      t = -QW'(Q14_ONE);
    end
    return t[VEC_W-1:0];
  endfunction

endpackage

// File: rtl/fly_camera_pose_update_unit.sv
// Fly camera pose unit: holds a Q16.16 position and yaw, pitch and roll binary
// angles, applies one opcode per request, then recomputes the Q1.14 look,
// strafe and up vectors and returns the pose as one result. The next request
// can be taken in the same cycle that the result appears. Three sine-cosine
// pairs go through one shared CORDIC stage (16 iterations plus setup and
// rounding, per angle), and the position and look-vector products share one
// 32x16 multiplier. in_stall is high from acceptance until the result is
// loaded into the output register; the output register frees the core while
// the result waits on out_stall. pitch_limit may only be written while the
// unit is idle.
module fly_camera_pose_update_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [fcpu_pkg::LIM_W-1:0]              cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [fcpu_pkg::OP_W-1:0]               in_opcode,
  input  logic signed [fcpu_pkg::POS_W-1:0]       in_step_or_x,
  input  logic signed [fcpu_pkg::POS_W-1:0]       in_new_y,
  input  logic signed [fcpu_pkg::POS_W-1:0]       in_new_z,
  input  logic signed [fcpu_pkg::ANG_W-1:0]       in_angle_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fcpu_pkg::POS_W-1:0]       out_pos_x,
  output logic signed [fcpu_pkg::POS_W-1:0]       out_pos_y,
  output logic signed [fcpu_pkg::POS_W-1:0]       out_pos_z,
  output logic signed [fcpu_pkg::VEC_W-1:0]       out_dir_x,
  output logic signed [fcpu_pkg::VEC_W-1:0]       out_dir_y,
  output logic signed [fcpu_pkg::VEC_W-1:0]       out_dir_z,
  output logic signed [fcpu_pkg::VEC_W-1:0]       out_up_x,
  output logic signed [fcpu_pkg::VEC_W-1:0]       out_up_y
);

  localparam int POS_W  = fcpu_pkg::POS_W;
  localparam int VEC_W  = fcpu_pkg::VEC_W;
  localparam int ANG_W  = fcpu_pkg::ANG_W;
  localparam int LIM_W  = fcpu_pkg::LIM_W;
  localparam int CW     = fcpu_pkg::CW;
  localparam int ZW     = fcpu_pkg::ZW;
  localparam int PROD_W = fcpu_pkg::PROD_W;
  localparam int IT_W   = fcpu_pkg::IT_W;
  localparam int SUM_W  = POS_W + 4;
  localparam int PW     = ANG_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PACC,
    ST_CINIT,
    ST_CITER,
    ST_CFIN,
    ST_LMUL,
    ST_LACC,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [LIM_W-1:0]              lim_r, lim_nxt;
  logic [fcpu_pkg::OP_W-1:0]     op_r, op_nxt;
  logic signed [POS_W-1:0]       step_r, step_nxt;
  logic signed [POS_W-1:0]       pos_r [3];
  logic signed [POS_W-1:0]       pos_nxt [3];
  logic [ANG_W-1:0]              ang_r [3];
  logic [ANG_W-1:0]              ang_nxt [3];
  logic signed [VEC_W-1:0]       look_r [3];
  logic signed [VEC_W-1:0]       look_nxt [3];
  logic signed [VEC_W-1:0]       strafe_r [2];
  logic signed [VEC_W-1:0]       strafe_nxt [2];
  logic signed [VEC_W-1:0]       up_r [2];
  logic signed [VEC_W-1:0]       up_nxt [2];
  logic signed [VEC_W-1:0]       cos_r [3];
  logic signed [VEC_W-1:0]       cos_nxt [3];
  logic signed [VEC_W-1:0]       sin_r [3];
  logic signed [VEC_W-1:0]       sin_nxt [3];
  logic [1:0]                    k_r, k_nxt;
  logic [1:0]                    a_r, a_nxt;
  logic [IT_W-1:0]               it_r, it_nxt;
  logic signed [CW-1:0]          x_r, x_nxt;
  logic signed [CW-1:0]          y_r, y_nxt;
  logic signed [ZW-1:0]          z_r, z_nxt;
  logic                          flip_r, flip_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]       out_pos_r [3];
  logic signed [POS_W-1:0]       out_pos_nxt [3];
  logic signed [VEC_W-1:0]       out_dir_r [3];
  logic signed [VEC_W-1:0]       out_dir_nxt [3];
  logic signed [VEC_W-1:0]       out_up_r [2];
  logic signed [VEC_W-1:0]       out_up_nxt [2];

  always_comb begin
    logic signed [POS_W-1:0]  mul_a;
    logic signed [VEC_W-1:0]  mul_b;
    logic signed [VEC_W-1:0]  pvec;
    logic [1:0]               tgt;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  sum;
    logic signed [PW-1:0]     pch;
    logic signed [PW-1:0]     lim_s;
    logic [ANG_W-1:0]         ang_sel;
    logic                     flp;
    logic signed [CW-1:0]     dx;
    logic signed [CW-1:0]     dy;
    logic signed [ZW-1:0]     atn;
    logic signed [VEC_W-1:0]  cq;
    logic signed [VEC_W-1:0]  sq;
    logic signed [POS_W:0]    fly_sum;
    logic                     last_p;

    state_nxt     = state_r;
    lim_nxt       = lim_r;
    op_nxt        = op_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    ang_nxt       = ang_r;
    look_nxt      = look_r;
    strafe_nxt    = strafe_r;
    up_nxt        = up_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    it_nxt        = it_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    flip_nxt      = flip_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_dir_nxt   = out_dir_r;
    out_up_nxt    = out_up_r;

    if (cfg_wr_en) begin
      lim_nxt = cfg_wr_data;
    end

    // shared multiplier operands
    unique case (k_r)
      2'd0:    pvec = (op_r == fcpu_pkg::OP_MOVE) ? look_r[0] : strafe_r[0];
      2'd1:    pvec = (op_r == fcpu_pkg::OP_MOVE) ? look_r[1] : strafe_r[1];
      default: pvec = look_r[2];
    endcase
    if (state_r == ST_LMUL) begin
      mul_a = POS_W'((k_r == 2'd0) ? cos_r[0] : sin_r[0]);
      mul_b = cos_r[1];
    end else begin
      mul_a = step_r;
      mul_b = pvec;
    end
    rnd = prod_r + PROD_W'(fcpu_pkg::PROD_RND);

    tgt = k_r;
    if (op_r == fcpu_pkg::OP_STRAFE && k_r == 2'd1) begin
      tgt = 2'd2;
    end
    last_p = (op_r == fcpu_pkg::OP_MOVE) ? (k_r == 2'd2) : (k_r == 2'd1);

    // position accumulate with saturation
    unique case (tgt)
      2'd0:    sum = SUM_W'(pos_r[0]);
      2'd1:    sum = SUM_W'(pos_r[1]);
      default: sum = SUM_W'(pos_r[2]);
    endcase
    sum = sum + SUM_W'(rnd >>> 14);
    if (sum > SUM_W'(32'sh7FFFFFFF)) begin
      sum = SUM_W'(32'sh7FFFFFFF);
    end else if (sum < SUM_W'(-33'sh80000000)) begin
      sum = SUM_W'(-33'sh80000000);
    end

    fly_sum = (POS_W+1)'(pos_r[1]) + (POS_W+1)'(step_r);
    if (fly_sum[POS_W] != fly_sum[POS_W-1]) begin
      fly_sum = fly_sum[POS_W] ? (POS_W+1)'(-33'sh80000000) : (POS_W+1)'(32'sh7FFFFFFF);
    end

    pch   = PW'(signed'(ang_r[1])) + PW'(signed'(step_r[ANG_W-1:0]));
    lim_s = PW'(lim_r);
    if (pch < -lim_s) begin
      pch = -lim_s;
    end
    if (pch > lim_s) begin
      pch = lim_s;
    end

    // cordic stage
    unique case (a_r)
      2'd0:    ang_sel = ang_r[0];
      2'd1:    ang_sel = ang_r[1];
      default: ang_sel = ang_r[2];
    endcase
    flp = ang_sel[ANG_W-1] ^ ang_sel[ANG_W-2];
    dx  = y_r >>> it_r;
    dy  = x_r >>> it_r;
    atn = ZW'(fcpu_pkg::atan_lookup(fcpu_pkg::ATAN_IDX_W'(it_r)));
    cq  = fcpu_pkg::to_q14(x_r);
    sq  = fcpu_pkg::to_q14(y_r);
    if (flip_r) begin
      cq = -cq;
      sq = -sq;
    end

    prod_nxt = mul_a * mul_b;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_opcode;
          step_nxt = in_step_or_x;
          k_nxt    = 2'd0;
          a_nxt    = 2'd0;
          state_nxt = ST_CINIT;
          unique case (in_opcode)
            fcpu_pkg::OP_SETPOS: begin
              pos_nxt[0] = in_step_or_x;
              pos_nxt[1] = in_new_y;
              pos_nxt[2] = in_new_z;
            end
            fcpu_pkg::OP_MOVE, fcpu_pkg::OP_STRAFE: begin
              state_nxt = ST_PMUL;
            end
            fcpu_pkg::OP_ADDYAW:   ang_nxt[0] = ang_r[0] + in_angle_in;
            fcpu_pkg::OP_ADDROLL:  ang_nxt[2] = ang_r[2] + in_angle_in;
            fcpu_pkg::OP_SETYAW:   ang_nxt[0] = in_angle_in;
            fcpu_pkg::OP_SETPITCH: ang_nxt[1] = in_angle_in;
            fcpu_pkg::OP_SETROLL:  ang_nxt[2] = in_angle_in;
            default: begin
            end
          endcase
          // fly and add pitch need the latched step / angle
          if (in_opcode == fcpu_pkg::OP_FLY || in_opcode == fcpu_pkg::OP_ADDPITCH) begin
            step_nxt = (in_opcode == fcpu_pkg::OP_FLY) ? in_step_or_x : POS_W'(in_angle_in);
            state_nxt = ST_PACC;
          end
        end
      end
      ST_PMUL: begin
        state_nxt = ST_PACC;
      end
      ST_PACC: begin
        if (op_r == fcpu_pkg::OP_FLY) begin
          pos_nxt[1] = fly_sum[POS_W-1:0];
          state_nxt  = ST_CINIT;
        end else if (op_r == fcpu_pkg::OP_ADDPITCH) begin
          ang_nxt[1] = pch[ANG_W-1:0];
          state_nxt  = ST_CINIT;
        end else begin
          unique case (tgt)
            2'd0:    pos_nxt[0] = sum[POS_W-1:0];
            2'd1:    pos_nxt[1] = sum[POS_W-1:0];
            default: pos_nxt[2] = sum[POS_W-1:0];
          endcase
          if (last_p) begin
            state_nxt = ST_CINIT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_PMUL;
          end
        end
      end
      ST_CINIT: begin
        x_nxt    = CW'(fcpu_pkg::CORDIC_X0);
        y_nxt    = '0;
        flip_nxt = flp;
        z_nxt    = ZW'(signed'({ang_sel[ANG_W-1] ^ flp, ang_sel[ANG_W-2:0], 16'b0}));
        it_nxt   = '0;
        state_nxt = ST_CITER;
      end
      ST_CITER: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atn;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atn;
        end
        it_nxt = it_r + IT_W'(1);
        if (it_r == IT_W'(fcpu_pkg::NSTEPS - 1)) begin
          state_nxt = ST_CFIN;
        end
      end
      ST_CFIN: begin
        unique case (a_r)
          2'd0:    begin cos_nxt[0] = cq; sin_nxt[0] = sq; end
          2'd1:    begin cos_nxt[1] = cq; sin_nxt[1] = sq; end
          default: begin cos_nxt[2] = cq; sin_nxt[2] = sq; end
        endcase
        if (a_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = ST_LMUL;
        end else begin
          a_nxt     = a_r + 2'd1;
          state_nxt = ST_CINIT;
        end
      end
      ST_LMUL: begin
        state_nxt = ST_LACC;
      end
      ST_LACC: begin
        if ((rnd >>> 14) > PROD_W'(fcpu_pkg::Q14_ONE)) begin
          cq = VEC_W'(fcpu_pkg::Q14_ONE);
        end else if ((rnd >>> 14) < -PROD_W'(fcpu_pkg::Q14_ONE)) begin
          cq = -VEC_W'(fcpu_pkg::Q14_ONE);
        end else begin
          cq = VEC_W'(rnd >>> 14);
        end
        if (k_r == 2'd0) begin
          look_nxt[0] = cq;
          k_nxt       = 2'd1;
          state_nxt   = ST_LMUL;
        end else begin
          look_nxt[2]   = cq;
          look_nxt[1]   = sin_r[1];
          strafe_nxt[0] = sin_r[0];
          strafe_nxt[1] = -cos_r[0];
          up_nxt[0]     = cos_r[2];
          up_nxt[1]     = sin_r[2];
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_dir_nxt   = look_r;
          out_up_nxt    = up_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lim_r       <= fcpu_pkg::PITCH_LIMIT_RST;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= fcpu_pkg::POS_Z_RST;
      ang_r[0]    <= '0;
      ang_r[1]    <= '0;
      ang_r[2]    <= '0;
      look_r[0]   <= VEC_W'(fcpu_pkg::Q14_ONE);
      look_r[1]   <= '0;
      look_r[2]   <= '0;
      strafe_r[0] <= '0;
      strafe_r[1] <= -VEC_W'(fcpu_pkg::Q14_ONE);
      up_r[0]     <= VEC_W'(fcpu_pkg::Q14_ONE);
      up_r[1]     <= '0;
      k_r         <= '0;
      a_r         <= '0;
      it_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lim_r       <= lim_nxt;
      pos_r       <= pos_nxt;
      ang_r       <= ang_nxt;
      look_r      <= look_nxt;
      strafe_r    <= strafe_nxt;
      up_r        <= up_nxt;
      k_r         <= k_nxt;
      a_r         <= a_nxt;
      it_r        <= it_nxt;
    end
    op_r      <= op_nxt;
    step_r    <= step_nxt;
    cos_r     <= cos_nxt;
    sin_r     <= sin_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    flip_r    <= flip_nxt;
    prod_r    <= prod_nxt;
    out_pos_r <= out_pos_nxt;
    out_dir_r <= out_dir_nxt;
    out_up_r  <= out_up_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_r[0];
  assign out_pos_y = out_pos_r[1];
  assign out_pos_z = out_pos_r[2];
  assign out_dir_x = out_dir_r[0];
  assign out_dir_y = out_dir_r[1];
  assign out_dir_z = out_dir_r[2];
  assign out_up_x  = out_up_r[0];
  assign out_up_y  = out_up_r[1];

endmodule
